FILE: rtl/acsa_pkg.sv
// shared types, constants and table functions for the converter scan averager
// no dependencies; imported by every module of the block
package acsa_pkg;

   localparam int CH_W     = 4;
   localparam int SAMPLE_W = 16;
   localparam int CONV_W   = 12;
   localparam int ACC_W    = 29;
   localparam int TICK_W   = 16;
   localparam int CNT_W    = 5;
   localparam int AVG_W    = 13;
   localparam int SCALED_W = 16;
   localparam int MASK_W   = 16;
   localparam int NUM_W    = ACC_W + 2;
   localparam int DEN_W    = TICK_W + 1;
   localparam int MAX_CHANNELS_DEFAULT = 16;

   // floor(x*27/400) == (x*2264925) >> 25 for every non-negative 16-bit x
   localparam int SCALE_MULT_W = 22;
   localparam logic [SCALE_MULT_W-1:0] SCALE_MULT = 22'd2264925;
   localparam int SCALE_SHIFT = 25;
   localparam int PROD_W = (SAMPLE_W - 1) + SCALE_MULT_W;

   localparam logic [NUM_W-1:0] LEVEL_LIMIT = NUM_W'(700);
   localparam logic [NUM_W-1:0] SAT_LIMIT   = NUM_W'(4095);
   localparam logic [SCALED_W-1:0] SCALED_MAX = 16'hFFFF;

   localparam logic [1:0] KIND_SELECT  = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_AVERAGE = 2'd2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT  = 2'd1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       bus_idle;
      logic                       config_write_pending;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [7:0]          device_address;
      logic [7:0]          mux_byte;
      logic [CH_W-1:0]     channel;
      logic [AVG_W-1:0]    average;
      logic [SCALED_W-1:0] scaled_average;
      logic [MASK_W-1:0]   level_mask;
      logic                last;
   } rsp_type;

   // one classified tick handed from front to back
   typedef struct packed {
      logic              store_en;
      logic [CH_W-1:0]   store_ch;
      logic [CONV_W-1:0] store_val;
      logic              cmd_valid;
      logic [1:0]        cmd_kind;
      logic [7:0]        cmd_addr;
      logic [7:0]        cmd_mux;
      logic [CH_W-1:0]   cmd_ch;
      logic              do_avg;
      logic [TICK_W-1:0] ticks;
      logic [CNT_W-1:0]  n;
   } job_type;

   function automatic logic [7:0] addr_of(input logic [CH_W-1:0] ch);
      logic [7:0] a;
      case (ch[3:2])
         2'd0:    a = 8'h92;
         2'd1:    a = 8'h90;
         2'd2:    a = 8'h96;
         default: a = 8'h94;
      endcase
      return a;
   endfunction

   function automatic logic [7:0] mux_of(input logic [CH_W-1:0] ch);
      logic [7:0] m;
      case ({ch[3], ch[1:0]})
         3'd0:    m = 8'hF4;
         3'd1:    m = 8'hE4;
         3'd2:    m = 8'hD4;
         3'd3:    m = 8'hC4;
         3'd4:    m = 8'hC4;
         3'd5:    m = 8'hD4;
         3'd6:    m = 8'hE4;
         default: m = 8'hF4;
      endcase
      return m;
   endfunction

endpackage

FILE: rtl/acsa_front.sv
// front end: accepts scan ticks, tracks phase, channel and tick count,
// converts the reading and classifies the tick into a job; uses acsa_pkg
module acsa_front
   import acsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_word,
   input  logic [TICK_W-1:0] avg_len,
   input  logic [CNT_W-1:0]  eff_n,
   input  logic              q_full,
   output logic              push,
   output job_type           job
);

   logic              phase_ff, phase_in;
   logic [CH_W-1:0]   cur_ch_ff, cur_ch_in;
   logic [TICK_W-1:0] tick_ff, tick_in;

   logic [PROD_W-1:0] prod;
   logic [CNT_W-1:0]  ch_inc;
   logic [CH_W-1:0]   ch_nx;
   logic [TICK_W-1:0] tick_nx;
   logic              do_avg;

   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;

   assign prod    = PROD_W'(req_word.sample[SAMPLE_W-2:0]) * PROD_W'(SCALE_MULT);
   assign ch_inc  = CNT_W'(cur_ch_ff) + CNT_W'(1);
   assign ch_nx   = (ch_inc >= eff_n) ? '0 : ch_inc[CH_W-1:0];
   assign tick_nx = tick_ff + TICK_W'(1);
   assign do_avg  = (tick_nx >= avg_len) && (tick_nx != '0);

   always_comb begin
      job           = '0;
      job.do_avg    = do_avg;
      job.ticks     = tick_nx;
      job.n         = eff_n;
      job.store_ch  = cur_ch_ff;
      job.store_val = req_word.sample[SAMPLE_W-1] ? '0 : prod[SCALE_SHIFT +: CONV_W];
      if (!phase_ff) begin
         job.store_en  = 1'b1;
         job.cmd_valid = req_word.bus_idle;
         job.cmd_kind  = KIND_SELECT;
         job.cmd_addr  = addr_of(ch_nx);
         job.cmd_mux   = mux_of(ch_nx);
         job.cmd_ch    = ch_nx;
      end else begin
         job.cmd_valid = req_word.bus_idle && !req_word.config_write_pending;
         job.cmd_kind  = KIND_READ;
         job.cmd_addr  = addr_of(cur_ch_ff);
         job.cmd_ch    = cur_ch_ff;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      cur_ch_in = cur_ch_ff;
      tick_in   = tick_ff;
      if (push) begin
         phase_in = !phase_ff;
         if (!phase_ff) begin
            cur_ch_in = ch_nx;
         end
         tick_in = do_avg ? '0 : tick_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         cur_ch_ff <= '0;
         tick_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         cur_ch_ff <= cur_ch_in;
         tick_ff   <= tick_in;
      end
   end

endmodule

FILE: rtl/acsa_queue.sv
// two-entry job queue between front and back; uses acsa_pkg
module acsa_queue
   import acsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    full,
   output logic    empty
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/acsa_div.sv
// restoring divider, one quotient bit per cycle; uses acsa_pkg
// done pulses in the cycle after the last step, with the quotient on quo
module acsa_div
   import acsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int STEP_W = $clog2(NUM_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign done  = done_ff;
   assign quo   = num_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W - 1);
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

FILE: rtl/acsa_back.sv
// back end: stores converted values, sweeps the accumulators, runs the
// averaging divider and drives the result register; uses acsa_pkg, acsa_div
module acsa_back
   import acsa_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   localparam int IDX_W = $clog2(MAX_CHANNELS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CMD_W = 3'd1;
   localparam logic [2:0] S_ACC   = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_AVG_W = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   job_type           job_ff, job_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CONV_W-1:0] conv_ff [MAX_CHANNELS];
   logic [ACC_W-1:0]  acc_ff  [MAX_CHANNELS];

   logic              conv_we, acc_we, div_start, div_done, last_ch;
   logic [ACC_W-1:0]  sum, acc_wd;
   logic [NUM_W-1:0]  div_num, quo;
   logic [DEN_W-1:0]  div_den;
   logic [MASK_W-1:0] mask_nx;
   logic [IDX_W-1:0]  idx;

   assign idx      = ch_ff[IDX_W-1:0];
   assign sum      = acc_ff[idx] + ACC_W'({conv_ff[idx], 1'b0});
   assign div_num  = {sum, 1'b0} + NUM_W'(job_ff.ticks);
   assign div_den  = {job_ff.ticks, 1'b0};
   assign last_ch  = (CNT_W'(ch_ff) + CNT_W'(1)) == job_ff.n;
   assign mask_nx  = (quo >= LEVEL_LIMIT) ? (mask_ff | (MASK_W'(1) << ch_ff)) : mask_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   acsa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      mask_in      = mask_ff;
      job_in       = job_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      pop          = 1'b0;
      conv_we      = 1'b0;
      acc_we       = 1'b0;
      acc_wd       = sum;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               job_in  = q_job;
               conv_we = q_job.store_en;
               mask_in = '0;
               ch_in   = '0;
               if (q_job.cmd_valid) begin
                  rsp_in                = '0;
                  rsp_in.kind           = q_job.cmd_kind;
                  rsp_in.device_address = q_job.cmd_addr;
                  rsp_in.mux_byte       = q_job.cmd_mux;
                  rsp_in.channel        = q_job.cmd_ch;
                  rsp_in.last           = !q_job.do_avg;
                  rsp_valid_in          = 1'b1;
                  state_in              = S_CMD_W;
               end else begin
                  state_in = S_ACC;
               end
            end
         end
         S_CMD_W: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_ACC;
            end
         end
         S_ACC: begin
            acc_we = 1'b1;
            if (job_ff.do_avg) begin
               acc_wd    = '0;
               div_start = 1'b1;
               state_in  = S_DIV;
            end else if (last_ch) begin
               state_in = S_IDLE;
            end else begin
               ch_in = ch_ff + CH_W'(1);
            end
         end
         S_DIV: begin
            if (div_done) begin
               rsp_in                = '0;
               rsp_in.kind           = KIND_AVERAGE;
               rsp_in.channel        = ch_ff;
               rsp_in.average        = quo[AVG_W-1:0];
               rsp_in.scaled_average = (quo < SAT_LIMIT) ? {quo[11:0], 4'b0000} : SCALED_MAX;
               rsp_in.level_mask     = last_ch ? mask_nx : '0;
               rsp_in.last           = last_ch;
               rsp_valid_in          = 1'b1;
               mask_in               = mask_nx;
               state_in              = S_AVG_W;
            end
         end
         S_AVG_W: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  ch_in    = ch_ff + CH_W'(1);
                  state_in = S_ACC;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      rsp_ff  <= rsp_in;
      ch_ff   <= ch_in;
      mask_ff <= mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            conv_ff[i] <= '0;
            acc_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (conv_we) begin
            conv_ff[q_job.store_ch[IDX_W-1:0]] <= q_job.store_val;
         end
         if (acc_we) begin
            acc_ff[idx] <= acc_wd;
         end
      end
   end

`ifndef SYNTH
   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_CMD_W || state_ff == S_AVG_W))
      else $error("result valid outside a wait state");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished while not waited for");
   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> (CNT_W'(ch_ff) < job_ff.n))
      else $error("accumulator sweep beyond channel count");
`endif

endmodule

FILE: rtl/adc_channel_scan_averager_top.sv
// top level of the converter scan averager: config registers, front end,
// job queue and back end; uses acsa_pkg, acsa_front, acsa_queue, acsa_back
//
// each req word is one scan tick. the front end takes a word whenever its
// two-entry job queue has room, so it keeps accepting while the
// back end works or while a result word waits on rsp. the back end picks
// up a job, waits out the rsp handshake for a command word, then updates
// the accumulators channel by channel. on an averaging tick each channel
// instead goes through the bit-serial divider, which runs 31 steps, and
// then the result word waits for rsp_ready. all stored values reset to
// zero at once, no clearing pass. config writes take effect at the next tick.
module adc_channel_scan_averager_top
   import acsa_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_word,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // config registers
   logic [TICK_W-1:0] avg_len_ff, avg_len_in;
   logic [CNT_W-1:0]  ch_count_ff, ch_count_in;
   logic [CNT_W-1:0]  eff_n;

   // front to queue to back
   logic    push, pop, q_full, q_empty;
   job_type push_job, q_job;

   always_comb begin
      avg_len_in  = avg_len_ff;
      ch_count_in = ch_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_AVERAGE_LENGTH: avg_len_in  = csr_wdata[TICK_W-1:0];
            CSR_CHANNEL_COUNT:  ch_count_in = csr_wdata[CNT_W-1:0];
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_len_ff  <= TICK_W'(1);
         ch_count_ff <= CNT_W'(MAX_CHANNELS_DEFAULT);
      end else begin
         avg_len_ff  <= avg_len_in;
         ch_count_ff <= ch_count_in;
      end
   end

   // channel count saturates at the build limit, zero acts as one
   assign eff_n = (ch_count_ff > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) :
                  (ch_count_ff == '0) ? CNT_W'(1) : ch_count_ff;

   acsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .avg_len   (avg_len_ff),
      .eff_n     (eff_n),
      .q_full    (q_full),
      .push      (push),
      .job       (push_job)
   );

   acsa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (q_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   acsa_back #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (q_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: test/tb_adc_channel_scan_averager_top.sv
// testbench for the converter scan averager: directed and random scan ticks,
// self-checking against an in-bench model of tick, command and average words
// depends on acsa_pkg and adc_channel_scan_averager_top
module tb_adc_channel_scan_averager_top;
   import acsa_pkg::*;

   // scan model plus queue of expected rsp words
   class scan_scoreboard;
      logic [15:0] avg_len;
      logic [4:0]  chan_cnt;
      bit          odd_tick;
      logic [3:0]  cur_ch;
      logic [11:0] conv [16];
      logic [28:0] acc [16];
      logic [15:0] ticks;
      rsp_type     pending_words [$];
      int          mismatches;

      function new();
         avg_len = 16'd1;
         chan_cnt = 5'd16;
         odd_tick = 0;
         cur_ch = '0;
         ticks = '0;
         mismatches = 0;
         for (int i = 0; i < 16; i++) begin
            conv[i] = '0;
            acc[i] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
         if (idx == CSR_AVERAGE_LENGTH) avg_len = val;
         else if (idx == CSR_CHANNEL_COUNT) chan_cnt = val[4:0];
      endfunction

      // note one accepted tick and queue the words it causes
      function void note_tick(req_type t);
         int unsigned n, ch, mask, k;
         longint unsigned num, den, avg;
         rsp_type w;
         k = 0;
         n = (chan_cnt > 16) ? 16 : ((chan_cnt == 0) ? 1 : chan_cnt);
         if (!odd_tick) begin
            ch = cur_ch;
            conv[ch] = t.sample[15] ? 12'd0 : 12'((int'(t.sample) * 27) / 400);
            ch++;
            if (ch >= n) ch = 0;
            cur_ch = 4'(ch);
            if (t.bus_idle) begin
               w = '0;
               w.kind = KIND_SELECT;
               w.device_address = addr_byte(cur_ch);
               w.mux_byte = select_byte(cur_ch);
               w.channel = cur_ch;
               pending_words.push_back(w);
               k++;
            end
         end else if (t.bus_idle && !t.config_write_pending) begin
            w = '0;
            w.kind = KIND_READ;
            w.device_address = addr_byte(cur_ch);
            w.channel = cur_ch;
            pending_words.push_back(w);
            k++;
         end
         odd_tick = !odd_tick;
         ticks++;
         for (int i = 0; i < n; i++) acc[i] = acc[i] + 29'(2 * conv[i]);
         if (ticks >= avg_len && ticks != 0) begin
            mask = 0;
            den = ticks;
            for (int i = 0; i < n; i++) begin
               num = acc[i];
               avg = (2 * num + den) / (2 * den);
               acc[i] = '0;
               if (avg >= 700) mask |= 1 << i;
               w = '0;
               w.kind = KIND_AVERAGE;
               w.channel = 4'(i);
               w.average = 13'(avg);
               w.scaled_average = (avg < 4095) ? 16'(avg * 16) : 16'hFFFF;
               pending_words.push_back(w);
               k++;
            end
            pending_words[$].level_mask = 16'(mask);
            ticks = '0;
         end
         if (k > 0) pending_words[$].last = 1'b1;
      endfunction

      function logic [7:0] addr_byte(logic [3:0] c);
         logic [7:0] tab [4] = '{8'h92, 8'h90, 8'h96, 8'h94};
         return tab[c[3:2]];
      endfunction

      function logic [7:0] select_byte(logic [3:0] c);
         logic [7:0] lo [4] = '{8'hF4, 8'hE4, 8'hD4, 8'hC4};
         return c[3] ? lo[3 - c[1:0]] : lo[c[1:0]];
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp_w;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word %h", got);
            return;
         end
         exp_w = pending_words.pop_front();
         if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp mismatch: exp kind %0d addr %h mux %h ch %0d ",
                  "avg %0d sc %0d mask %h last %b / got kind %0d addr %h ",
                  "mux %h ch %0d avg %0d sc %0d mask %h last %b",
                  exp_w.kind, exp_w.device_address, exp_w.mux_byte, exp_w.channel,
                  exp_w.average, exp_w.scaled_average, exp_w.level_mask, exp_w.last,
                  got.kind, got.device_address, got.mux_byte, got.channel,
                  got.average, got.scaled_average, got.level_mask, got.last);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_word;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   scan_scoreboard sb;
   int  send_idle_pct;  // chance per cycle that the sender holds off
   int  recv_idle_pct;  // chance per cycle that the receiver stalls
   int  cycle_count;

   adc_channel_scan_averager_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // rsp side: ready toggles at random on the falling edge, words checked at
   // the rising edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_word);
      if (cycle_count > 3000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // present one tick word and hold it until the handshake; valid stays up
   // after the handshake until the next falling edge drive
   task automatic send_tick(req_type t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_tick(t);
   endtask

   // drop valid, drain every expected word, then a quiet spell for trailing work
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(negedge clock);
      repeat (700) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   function automatic req_type rand_tick();
      req_type t;
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) t.sample = 16'sh7FFF;
      else if (sel == 1) t.sample = 16'sh8000;
      else if (sel < 5) t.sample = 16'($urandom_range(65535));
      else t.sample = 16'($urandom_range(32767));
      t.bus_idle = ($urandom_range(3) != 0);
      t.config_write_pending = ($urandom_range(3) == 0);
      return t;
   endfunction

   initial begin
      req_type t;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_AVERAGE_LENGTH;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      cycle_count = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, both phases, every bus combination
      write_csr(CSR_AVERAGE_LENGTH, 16'd1);
      write_csr(CSR_CHANNEL_COUNT, 5'd16);
      t.sample = 16'sh7FFF; t.bus_idle = 1; t.config_write_pending = 0; send_tick(t);
      t.sample = -16'sd1;   t.bus_idle = 1; t.config_write_pending = 0; send_tick(t);
      t.sample = 16'sh8000; t.bus_idle = 0; t.config_write_pending = 1; send_tick(t);
      t.sample = 16'sd0;    t.bus_idle = 1; t.config_write_pending = 1; send_tick(t);
      t.sample = 16'sd15;   t.bus_idle = 0; t.config_write_pending = 0; send_tick(t);
      t.sample = 16'sd10371; t.bus_idle = 1; t.config_write_pending = 0; send_tick(t);
      wait_idle();

      // zero length emits averages on every tick
      write_csr(CSR_AVERAGE_LENGTH, 16'd0);
      write_csr(CSR_CHANNEL_COUNT, 5'd8);
      for (int i = 0; i < 4; i++) send_tick(rand_tick());
      wait_idle();

      // odd and out-of-range counts, including the stale channel wrap
      write_csr(CSR_CHANNEL_COUNT, 5'd0);
      for (int i = 0; i < 3; i++) send_tick(rand_tick());
      wait_idle();
      write_csr(CSR_CHANNEL_COUNT, 5'd31);
      write_csr(CSR_AVERAGE_LENGTH, 16'd3);
      for (int i = 0; i < 6; i++) send_tick(rand_tick());
      wait_idle();

      // random phases with rotating idle patterns and settings
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 80 : 0;
         recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 26 : 0;
         write_csr(CSR_CHANNEL_COUNT, (ph == 1) ? 5'd8 : 5'($urandom_range(8, 16)));
         write_csr(CSR_AVERAGE_LENGTH, (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 12)));
         for (int i = 0; i < 85; i++) begin
            t = rand_tick();
            if (i % 20 == 0) t.sample = 16'sh7FFF;
            send_tick(t);
         end
         wait_idle();
      end
      // flush the long accumulation of the last phase
      write_csr(CSR_AVERAGE_LENGTH, 16'd1);
      send_tick(rand_tick());
      wait_idle();

      if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
